[rtl/run_literal_rle_decoder_defines.svh]
// Assertion macros shared by the run/literal decoder RTL.
`ifndef RUN_LITERAL_RLE_DECODER_DEFINES_SVH
`define RUN_LITERAL_RLE_DECODER_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define RLD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define RLD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rld_pkg.sv]
// Shared types and constants for the run/literal decoder.
`default_nettype none
package rld_pkg;

   // Field widths
   localparam int unsigned CODE_BITS   = 8;
   localparam int unsigned LEN_BITS    = 7;
   localparam int unsigned OUT_ADDR_BITS = 14;
   localparam int unsigned COUNT_BITS  = 15;
   localparam int unsigned CSR_DATA_BITS = 15;
   localparam int unsigned CSR_IDX_BITS  = 2;

   // Default internal address width
   localparam int unsigned ADDR_BITS_DEF = 14;

   // Command queue between front and back (power of two)
   localparam int unsigned QDEPTH    = 2;
   localparam int unsigned QPTR_BITS = $clog2(QDEPTH);
   localparam int unsigned QCNT_BITS = $clog2(QDEPTH + 1);

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOTAL_COUNT   = 2'd1;

   // Header byte fields
   localparam logic [CODE_BITS-1:0] HDR_RUN_FLAG = 8'h80;
   localparam logic [CODE_BITS-1:0] HDR_LEN_MASK = 8'h7f;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_RUNVAL  = 2'd1,
      PH_LITERAL = 2'd2
   } phase_type;

   // One classified write command, address assigned later
   typedef struct packed {
      logic [CODE_BITS-1:0] value;
      logic [LEN_BITS-1:0]  length;
      logic                 last;
   } cmd_type;

   // Rearm request with the register values that take effect
   typedef struct packed {
      logic                         rearm;
      logic [OUT_ADDR_BITS-1:0]     start_address;
      logic [COUNT_BITS-1:0]        total_count;
   } cfg_type;

endpackage
`default_nettype wire

[rtl/rld_front.sv]
// Front end: takes code bytes, tracks header/run/literal phase and byte budget.
`default_nettype none
`include "run_literal_rle_decoder_defines.svh"
module rld_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rld_pkg::cfg_type  cfg,
   input  wire logic              accept,
   input  wire logic [7:0]        code_byte,
   output logic                   push,
   output rld_pkg::cmd_type       cmd
);
   import rld_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [LEN_BITS-1:0]     group_ff, group_in;
   logic [LEN_BITS-1:0]     run_ff, run_in;
   logic [COUNT_BITS-1:0]   remain_ff, remain_in;
   logic                    finished_ff, finished_in;

   logic [LEN_BITS-1:0]     hdr_len;
   logic [COUNT_BITS-1:0]   hdr_len_wide;
   logic                    lit_last;

   assign hdr_len      = LEN_BITS'(code_byte & HDR_LEN_MASK);
   assign hdr_len_wide = COUNT_BITS'(hdr_len);
   assign lit_last     = (remain_ff == '0) && (group_ff <= LEN_BITS'(1));

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         group_ff    <= '0;
         run_ff      <= '0;
         remain_ff   <= '0;
         finished_ff <= 1'b1;
      end else begin
         phase_ff    <= phase_in;
         group_ff    <= group_in;
         run_ff      <= run_in;
         remain_ff   <= remain_in;
         finished_ff <= finished_in;
      end
   end

   // Byte classification and next state
   always_comb begin
      phase_in    = phase_ff;
      group_in    = group_ff;
      run_in      = run_ff;
      remain_in   = remain_ff;
      finished_in = finished_ff;
      push        = 1'b0;
      cmd         = '0;
      if (cfg.rearm) begin
         phase_in    = PH_HEADER;
         group_in    = '0;
         run_in      = '0;
         remain_in   = cfg.total_count;
         finished_in = (cfg.total_count == '0);
      end else if (accept && !finished_ff) begin
         case (phase_ff)
            PH_RUNVAL: begin
               phase_in = PH_HEADER;
               if (run_ff != '0) begin
                  push       = 1'b1;
                  cmd.value  = code_byte;
                  cmd.length = run_ff;
                  cmd.last   = (remain_ff == '0);
                  if (remain_ff == '0) begin
                     finished_in = 1'b1;
                  end
               end
            end
            PH_LITERAL: begin
               push       = 1'b1;
               cmd.value  = code_byte;
               cmd.length = LEN_BITS'(1);
               cmd.last   = lit_last;
               group_in   = (group_ff != '0) ? group_ff - LEN_BITS'(1) : '0;
               if (group_in == '0) begin
                  phase_in = PH_HEADER;
               end
               if (lit_last) begin
                  finished_in = 1'b1;
               end
            end
            default: begin
               // header byte, also taken for the unused phase code
               remain_in = (hdr_len_wide >= remain_ff) ? '0 : remain_ff - hdr_len_wide;
               if ((code_byte & HDR_RUN_FLAG) != '0) begin
                  run_in   = hdr_len;
                  phase_in = PH_RUNVAL;
               end else begin
                  group_in = hdr_len;
                  phase_in = (hdr_len != '0) ? PH_LITERAL : PH_HEADER;
               end
            end
         endcase
      end
   end

   `RLD_ASSERT_NOW(a_no_cmd_after_end, clock, reset, finished_ff, !push, "command after end of stream")
   `RLD_ASSERT_NEXT(a_last_ends, clock, reset, push && cmd.last, finished_ff, "last command did not end stream")

endmodule
`default_nettype wire

[rtl/rld_queue.sv]
// Short command queue decoupling the front end from the address back end.
`default_nettype none
`include "run_literal_rle_decoder_defines.svh"
module rld_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rld_pkg::cmd_type  push_cmd,
   input  wire logic              pop,
   output rld_pkg::cmd_type       head_cmd,
   output logic                   full,
   output logic                   empty
);
   import rld_pkg::*;

   cmd_type                 mem_ff [QDEPTH];
   logic [QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]    count_ff, count_in;
   logic                    do_push, do_pop;

   assign full     = (count_ff == QCNT_BITS'(QDEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `RLD_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= QCNT_BITS'(QDEPTH), "queue overfilled")
   `RLD_ASSERT_NEXT(a_drain, clock, reset, do_pop && !do_push && count_ff == QCNT_BITS'(1), empty, "queue not empty after last transfer")

endmodule
`default_nettype wire

[rtl/rld_back.sv]
// Back end: assigns destination addresses and holds the result register.
`default_nettype none
`include "run_literal_rle_decoder_defines.svh"
module rld_back #(
   parameter int unsigned ADDR_BITS = rld_pkg::ADDR_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rld_pkg::cfg_type  cfg,
   input  wire rld_pkg::cmd_type  head_cmd,
   input  wire logic              q_empty,
   output logic                   q_pop,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output logic [13:0]            rsp_write_address,
   output logic [7:0]             rsp_fill_value,
   output logic [6:0]             rsp_fill_length,
   output logic                   rsp_last
);
   import rld_pkg::*;

   logic [ADDR_BITS-1:0]                 next_addr_ff, next_addr_in;
   logic [ADDR_BITS+OUT_ADDR_BITS-1:0]   start_ext;
   logic [ADDR_BITS+OUT_ADDR_BITS-1:0]   addr_ext;
   logic                                 valid_ff, valid_in;
   logic [OUT_ADDR_BITS-1:0]             addr_ff;
   cmd_type                              cmd_ff;

   assign start_ext = {{ADDR_BITS{1'b0}}, cfg.start_address};
   assign addr_ext  = {{OUT_ADDR_BITS{1'b0}}, next_addr_ff};

   // Take the queue head when the result register is free or being drained
   assign q_pop = !q_empty && (!valid_ff || rsp_pop);

   always_comb begin
      next_addr_in = next_addr_ff;
      if (cfg.rearm) begin
         next_addr_in = start_ext[ADDR_BITS-1:0];
      end else if (q_pop) begin
         next_addr_in = next_addr_ff + ADDR_BITS'(head_cmd.length);
      end
      valid_in = q_pop ? 1'b1 : (rsp_pop ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         next_addr_ff <= '0;
      end else begin
         valid_ff     <= valid_in;
         next_addr_ff <= next_addr_in;
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      if (q_pop) begin
         addr_ff <= addr_ext[OUT_ADDR_BITS-1:0];
         cmd_ff  <= head_cmd;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_write_address = addr_ff;
   assign rsp_fill_value    = cmd_ff.value;
   assign rsp_fill_length   = cmd_ff.length;
   assign rsp_last          = cmd_ff.last;

   `RLD_ASSERT_NOW(a_nonzero_len, clock, reset, q_pop, head_cmd.length != '0, "zero-length command queued")

endmodule
`default_nettype wire

[rtl/run_literal_rle_decoder.sv]
// Top level of the run/literal byte-stream decoder with its register file.
//
//   channel | direction | handshake                | payload
//   req     | in        | push / full              | code_byte
//   rsp     | out       | pop / empty              | write_address, fill_value,
//           |           |                          | fill_length, last
//   csr     | in        | valid / ready            | index, data
//
// One code byte is taken per cycle while req_full is low; a command is written
// into the queue at the edge that accepts its byte, and the back end moves it
// into the result register, assigning its address, once that register is free
// or being popped. Reset is synchronous; after reset total_count is zero and
// input is ignored. A full queue (two commands) stalls input via req_full.
`default_nettype none
module run_literal_rle_decoder #(
   parameter int unsigned ADDR_BITS = rld_pkg::ADDR_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire logic [7:0]                          req_code_byte,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output logic [13:0]                              rsp_write_address,
   output logic [7:0]                               rsp_fill_value,
   output logic [6:0]                               rsp_fill_length,
   output logic                                     rsp_last,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rld_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [rld_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import rld_pkg::*;

   logic [OUT_ADDR_BITS-1:0]  start_ff, start_in;
   logic [COUNT_BITS-1:0]     total_ff, total_in;
   cfg_type                   cfg;
   logic                      accept;
   logic                      f_push;
   cmd_type                   f_cmd;
   cmd_type                   q_head;
   logic                      q_full, q_empty, q_pop;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !q_full;
   assign req_full  = q_full;

   // Register file decode; a valid index rearms the decoder
   always_comb begin
      start_in  = start_ff;
      total_in  = total_ff;
      cfg.rearm = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_ADDRESS: begin
               start_in  = OUT_ADDR_BITS'(csr_data);
               cfg.rearm = 1'b1;
            end
            CSR_TOTAL_COUNT: begin
               total_in  = COUNT_BITS'(csr_data);
               cfg.rearm = 1'b1;
            end
            default: begin
            end
         endcase
      end
      cfg.start_address = start_in;
      cfg.total_count   = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         total_ff <= '0;
      end else begin
         start_ff <= start_in;
         total_ff <= total_in;
      end
   end

   rld_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .code_byte (req_code_byte),
      .push      (f_push),
      .cmd       (f_cmd)
   );

   rld_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_push),
      .push_cmd (f_cmd),
      .pop      (q_pop),
      .head_cmd (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   rld_back #(
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .head_cmd          (q_head),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_write_address (rsp_write_address),
      .rsp_fill_value    (rsp_fill_value),
      .rsp_fill_length   (rsp_fill_length),
      .rsp_last          (rsp_last)
   );

endmodule
`default_nettype wire
